[hw/rtl/mse_pkg.sv]
`default_nettype none
package mse_pkg;

    localparam int MAX_NODES_DEF    = 32;
    localparam int MAX_VSOURCES_DEF = 16;

    localparam logic [2:0] OP_REG_NODE = 3'd0;
    localparam logic [2:0] OP_RESISTOR = 3'd1;
    localparam logic [2:0] OP_VSOURCE  = 3'd2;
    localparam logic [2:0] OP_ISOURCE  = 3'd3;
    localparam logic [2:0] OP_READ_MAT = 3'd4;
    localparam logic [2:0] OP_READ_RHS = 3'd5;

    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_ZERO_RES   = 2'd1;
    localparam logic [1:0] STAT_TABLE_FULL = 2'd2;
    localparam logic [1:0] STAT_RANGE      = 2'd3;

    localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic       load;
        logic       scan;
        logic       reg_node;
        logic       div_start;
        logic       step_addr;
        logic       step_rd;
        logic       step_wr;
        logic       publish;
        logic       clear;
        logic [2:0] step;
    } dp_cmd_t;

    typedef struct packed {
        logic       clr_done;
        logic       scan_done;
        logic       div_done;
        logic       skip;
        logic [2:0] opcode;
    } dp_stat_t;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sh0_7fff_ffff)
        begin
            r = VAL_MAX;
        end
        else if (v < -33'sh0_8000_0000)
        begin
            r = VAL_MIN;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/mse_req_if.sv]
`default_nettype none
interface mse_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic [15:0]        node_a;
    logic [15:0]        node_b;
    logic signed [31:0] elem_value;
    logic [3:0]         source_slot;
    logic [5:0]         read_row;
    logic [5:0]         read_col;

    modport source (output valid, opcode, node_a, node_b, elem_value, source_slot,
                    read_row, read_col, input ready);
    modport sink (input valid, opcode, node_a, node_b, elem_value, source_slot,
                  read_row, read_col, output ready);
endinterface
`default_nettype wire

[hw/rtl/mse_rsp_if.sv]
`default_nettype none
interface mse_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [5:0]         node_count;

    modport source (output valid, read_value, status, node_count, input ready);
    modport sink (input valid, read_value, status, node_count, output ready);
endinterface
`default_nettype wire

[hw/rtl/mse_divider.sv]
`default_nettype none
module mse_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] divisor,
    output logic [32:0]      quot,
    output logic             done
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [32:0] num_reg;
    logic [31:0] den_reg;
    logic [32:0] quot_reg;
    logic [32:0] trial;
    logic        qbit;

    // rounded reciprocal numerator 2^32 + d/2
    always_comb
    begin
        trial = {rem_reg, num_reg[32]};
        qbit  = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd33;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            num_reg  <= {1'b1, 32'd0} + {2'b00, divisor[31:1]};
            den_reg  <= divisor;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= qbit ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
            num_reg  <= {num_reg[31:0], 1'b0};
            quot_reg <= {quot_reg[31:0], qbit};
        end
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

[hw/rtl/mse_datapath.sv]
`default_nettype none
module mse_datapath #(
    parameter int MAX_NODES    = mse_pkg::MAX_NODES_DEF,
    parameter int MAX_VSOURCES = mse_pkg::MAX_VSOURCES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mse_pkg::dp_cmd_t  cmd,
    output mse_pkg::dp_stat_t      stat,
    input  wire logic [2:0]        opcode,
    input  wire logic [15:0]       node_a,
    input  wire logic [15:0]       node_b,
    input  wire logic signed [31:0] elem_value,
    input  wire logic [3:0]        source_slot,
    input  wire logic [5:0]        read_row,
    input  wire logic [5:0]        read_col,
    output logic signed [31:0]     read_value,
    output logic [1:0]             status,
    output logic [5:0]             node_count
);

    localparam int DIM       = MAX_NODES + MAX_VSOURCES;
    localparam int MAT_DEPTH = DIM * DIM;
    localparam int NW        = $clog2(MAX_NODES);
    localparam int CW        = $clog2(MAX_NODES + 1);
    localparam int XW        = $clog2(DIM);
    localparam int AW        = $clog2(MAT_DEPTH);
    localparam int CMPW      = (XW > 6 ? XW : 6) + 1;
    localparam logic [AW-1:0] DIM_A   = AW'(DIM);
    localparam logic [AW-1:0] CLR_END = AW'(MAT_DEPTH - 1);

    logic [15:0]        nt_mem [MAX_NODES];
    logic signed [31:0] mat_mem [MAT_DEPTH];
    logic signed [31:0] rhs_mem [DIM];

    logic [2:0]         op_reg;
    logic [15:0]        na_reg;
    logic [15:0]        nb_reg;
    logic signed [31:0] val_reg;
    logic [3:0]         slot_reg;
    logic [5:0]         row_reg;
    logic [5:0]         col_reg;

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      scan_cnt_reg;
    logic               cmp_valid_reg;
    logic [NW-1:0]      cmp_idx_reg;
    logic [15:0]        nt_q_reg;
    logic               p_found_reg;
    logic               q_found_reg;
    logic [NW-1:0]      p_idx_reg;
    logic [NW-1:0]      q_idx_reg;
    logic [AW-1:0]      clr_cnt_reg;

    logic signed [31:0] g_reg;
    logic signed [31:0] res_val_reg;
    logic [1:0]         res_status_reg;

    logic [AW-1:0]      mat_addr_reg;
    logic [XW-1:0]      rhs_addr_reg;
    logic               en_reg;
    logic               to_rhs_reg;
    logic signed [31:0] wval_reg;
    logic signed [31:0] mat_q_reg;
    logic signed [31:0] rhs_q_reg;

    logic signed [31:0] out_val_reg;
    logic [1:0]         out_status_reg;
    logic [5:0]         out_count_reg;

    logic [32:0]        div_quot;
    logic               div_done;
    logic signed [31:0] g_new;
    logic signed [31:0] ng;
    logic signed [31:0] neg_val;
    logic [31:0]        mag;

    logic               row_bad;
    logic               col_bad;
    logic               slot_bad;
    logic               skip;
    logic [1:0]         pre_status;

    logic [XW-1:0]      p_x;
    logic [XW-1:0]      q_x;
    logic [XW-1:0]      r_x;
    logic [XW-1:0]      row_sel;
    logic [XW-1:0]      col_sel;
    logic               en_sel;
    logic               rhs_sel;
    logic signed [31:0] wv_sel;
    logic               both;

    logic               scan_issue;
    logic               nt_we;
    logic               mat_we;
    logic [AW-1:0]      mat_wa;
    logic signed [31:0] mat_wd;
    logic               rhs_we;
    logic [XW-1:0]      rhs_wa;
    logic signed [31:0] rhs_wd;

    mse_divider u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .divisor (mag),
        .quot    (div_quot),
        .done    (div_done)
    );

    always_comb
    begin
        mag = val_reg[31] ? 32'(-{1'b1, val_reg}) : val_reg;
        if (val_reg[31])
        begin
            g_new = (div_quot >= 33'h0_8000_0000) ? mse_pkg::VAL_MIN
                                                  : 32'(-div_quot);
        end
        else
        begin
            g_new = (div_quot > 33'h0_7fff_ffff) ? mse_pkg::VAL_MAX : div_quot[31:0];
        end
        ng      = (g_reg == mse_pkg::VAL_MIN) ? mse_pkg::VAL_MAX : -g_reg;
        neg_val = (val_reg == mse_pkg::VAL_MIN) ? mse_pkg::VAL_MAX : -val_reg;
    end

    // range checks and early status
    always_comb
    begin
        row_bad  = (CMPW'(row_reg) >= CMPW'(DIM));
        col_bad  = (CMPW'(col_reg) >= CMPW'(DIM));
        slot_bad = (7'(slot_reg) >= 7'(MAX_VSOURCES));
        skip       = 1'b0;
        pre_status = mse_pkg::STAT_OK;
        unique case (op_reg)
            mse_pkg::OP_RESISTOR:
            begin
                skip       = (val_reg == 32'sd0);
                pre_status = mse_pkg::STAT_ZERO_RES;
            end
            mse_pkg::OP_VSOURCE:
            begin
                skip       = slot_bad;
                pre_status = mse_pkg::STAT_RANGE;
            end
            mse_pkg::OP_READ_MAT:
            begin
                skip       = row_bad || col_bad;
                pre_status = mse_pkg::STAT_RANGE;
            end
            mse_pkg::OP_READ_RHS:
            begin
                skip       = row_bad;
                pre_status = mse_pkg::STAT_RANGE;
            end
            default:
            begin
                skip       = 1'b0;
                pre_status = mse_pkg::STAT_OK;
            end
        endcase
    end

    // stamp target selection
    always_comb
    begin
        p_x     = XW'(p_idx_reg);
        q_x     = XW'(q_idx_reg);
        r_x     = XW'((XW + 1)'(count_reg) + (XW + 1)'(slot_reg));
        both    = p_found_reg && q_found_reg;
        row_sel = p_x;
        col_sel = p_x;
        en_sel  = 1'b0;
        rhs_sel = 1'b0;
        wv_sel  = val_reg;
        unique case (op_reg)
            mse_pkg::OP_RESISTOR:
            begin
                case (cmd.step)
                    3'd0:
                    begin
                        row_sel = p_x; col_sel = p_x; en_sel = p_found_reg; wv_sel = g_reg;
                    end
                    3'd1:
                    begin
                        row_sel = q_x; col_sel = q_x; en_sel = q_found_reg; wv_sel = g_reg;
                    end
                    3'd2:
                    begin
                        row_sel = p_x; col_sel = q_x; en_sel = both; wv_sel = ng;
                    end
                    default:
                    begin
                        row_sel = q_x; col_sel = p_x; en_sel = both; wv_sel = ng;
                    end
                endcase
            end
            mse_pkg::OP_VSOURCE:
            begin
                case (cmd.step)
                    3'd0:
                    begin
                        row_sel = p_x; col_sel = r_x; en_sel = p_found_reg;
                        wv_sel = mse_pkg::Q_ONE;
                    end
                    3'd1:
                    begin
                        row_sel = r_x; col_sel = p_x; en_sel = p_found_reg;
                        wv_sel = mse_pkg::Q_ONE;
                    end
                    3'd2:
                    begin
                        row_sel = q_x; col_sel = r_x; en_sel = q_found_reg;
                        wv_sel = -mse_pkg::Q_ONE;
                    end
                    3'd3:
                    begin
                        row_sel = r_x; col_sel = q_x; en_sel = q_found_reg;
                        wv_sel = -mse_pkg::Q_ONE;
                    end
                    default:
                    begin
                        row_sel = r_x; en_sel = 1'b1; rhs_sel = 1'b1; wv_sel = val_reg;
                    end
                endcase
            end
            mse_pkg::OP_ISOURCE:
            begin
                rhs_sel = 1'b1;
                if (cmd.step == 3'd0)
                begin
                    row_sel = p_x; en_sel = p_found_reg; wv_sel = val_reg;
                end
                else
                begin
                    row_sel = q_x; en_sel = q_found_reg; wv_sel = neg_val;
                end
            end
            mse_pkg::OP_READ_MAT:
            begin
                row_sel = XW'(row_reg); col_sel = XW'(col_reg); en_sel = 1'b1;
            end
            mse_pkg::OP_READ_RHS:
            begin
                row_sel = XW'(row_reg); en_sel = 1'b1; rhs_sel = 1'b1;
            end
            default:
            begin
                en_sel = 1'b0;
            end
        endcase
    end

    // memory write ports
    always_comb
    begin
        scan_issue = cmd.scan && (scan_cnt_reg < count_reg);
        nt_we  = cmd.reg_node && (na_reg != 16'd0) && !p_found_reg
                 && (count_reg != CW'(MAX_NODES));
        mat_we = 1'b0;
        mat_wa = mat_addr_reg;
        mat_wd = wval_reg;
        rhs_we = 1'b0;
        rhs_wa = rhs_addr_reg;
        rhs_wd = wval_reg;
        if (cmd.clear)
        begin
            mat_we = 1'b1;
            mat_wa = clr_cnt_reg;
            mat_wd = '0;
            rhs_we = (clr_cnt_reg < AW'(DIM));
            rhs_wa = clr_cnt_reg[XW-1:0];
            rhs_wd = '0;
        end
        else if (cmd.step_wr && en_reg)
        begin
            case (op_reg)
                mse_pkg::OP_RESISTOR:
                begin
                    mat_we = 1'b1;
                    mat_wd = mse_pkg::sat33(33'(mat_q_reg) + 33'(wval_reg));
                end
                mse_pkg::OP_VSOURCE:
                begin
                    mat_we = !to_rhs_reg;
                    rhs_we = to_rhs_reg;
                end
                mse_pkg::OP_ISOURCE:
                begin
                    rhs_we = 1'b1;
                end
                default:
                begin
                    mat_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (nt_we)
        begin
            nt_mem[count_reg[NW-1:0]] <= na_reg;
        end
        if (scan_issue)
        begin
            nt_q_reg <= nt_mem[scan_cnt_reg[NW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mat_we)
        begin
            mat_mem[mat_wa] <= mat_wd;
        end
        if (cmd.step_rd)
        begin
            mat_q_reg <= mat_mem[mat_addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rhs_we)
        begin
            rhs_mem[rhs_wa] <= rhs_wd;
        end
        if (cmd.step_rd)
        begin
            rhs_q_reg <= rhs_mem[rhs_addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            scan_cnt_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            p_found_reg   <= 1'b0;
            q_found_reg   <= 1'b0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.clear && (clr_cnt_reg != CLR_END))
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.load)
            begin
                scan_cnt_reg  <= '0;
                cmp_valid_reg <= 1'b0;
                p_found_reg   <= 1'b0;
                q_found_reg   <= 1'b0;
            end
            else
            begin
                cmp_valid_reg <= scan_issue;
                if (scan_issue)
                begin
                    scan_cnt_reg <= scan_cnt_reg + CW'(1);
                end
                if (cmp_valid_reg)
                begin
                    if ((nt_q_reg == na_reg) && (na_reg != 16'd0))
                    begin
                        p_found_reg <= 1'b1;
                    end
                    if ((nt_q_reg == nb_reg) && (nb_reg != 16'd0))
                    begin
                        q_found_reg <= 1'b1;
                    end
                end
            end
            if (nt_we)
            begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_issue)
        begin
            cmp_idx_reg <= scan_cnt_reg[NW-1:0];
        end
        if (cmp_valid_reg && (nt_q_reg == na_reg))
        begin
            p_idx_reg <= cmp_idx_reg;
        end
        if (cmp_valid_reg && (nt_q_reg == nb_reg))
        begin
            q_idx_reg <= cmp_idx_reg;
        end
        if (cmd.load)
        begin
            op_reg         <= opcode;
            na_reg         <= node_a;
            nb_reg         <= node_b;
            val_reg        <= elem_value;
            slot_reg       <= source_slot;
            row_reg        <= read_row;
            col_reg        <= read_col;
            res_val_reg    <= '0;
            res_status_reg <= mse_pkg::STAT_OK;
        end
        if (cmd.reg_node && (na_reg != 16'd0) && !p_found_reg
            && (count_reg == CW'(MAX_NODES)))
        begin
            res_status_reg <= mse_pkg::STAT_TABLE_FULL;
        end
        if (div_done)
        begin
            g_reg <= g_new;
        end
        if (cmd.step_addr)
        begin
            mat_addr_reg <= AW'(AW'(row_sel) * DIM_A + AW'(col_sel));
            rhs_addr_reg <= row_sel;
            en_reg       <= en_sel;
            to_rhs_reg   <= rhs_sel;
            wval_reg     <= wv_sel;
        end
        if (cmd.step_wr && en_reg)
        begin
            if (op_reg == mse_pkg::OP_READ_MAT)
            begin
                res_val_reg <= mat_q_reg;
            end
            else if (op_reg == mse_pkg::OP_READ_RHS)
            begin
                res_val_reg <= rhs_q_reg;
            end
        end
        if (cmd.publish)
        begin
            out_val_reg    <= res_val_reg;
            out_status_reg <= skip ? pre_status : res_status_reg;
            out_count_reg  <= 6'(count_reg);
        end
    end

    always_comb
    begin
        stat.clr_done  = cmd.clear && (clr_cnt_reg == CLR_END);
        stat.scan_done = (scan_cnt_reg == count_reg) && !cmp_valid_reg;
        stat.div_done  = div_done;
        stat.skip      = skip;
        stat.opcode    = op_reg;
    end

    assign read_value = out_val_reg;
    assign status     = out_status_reg;
    assign node_count = out_count_reg;

endmodule
`default_nettype wire

[hw/rtl/mse_ctrl.sv]
`default_nettype none
module mse_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output mse_pkg::dp_cmd_t      cmd,
    input  wire mse_pkg::dp_stat_t stat
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DISPATCH,
        S_REG,
        S_DIV_START,
        S_DIV_WAIT,
        S_ADDR,
        S_RD,
        S_WR,
        S_FIN
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [2:0] step_reg;
    logic [2:0] step_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic [2:0] last_step;
    logic       out_free;

    always_comb
    begin
        case (stat.opcode)
            mse_pkg::OP_RESISTOR: last_step = 3'd3;
            mse_pkg::OP_VSOURCE:  last_step = 3'd4;
            mse_pkg::OP_ISOURCE:  last_step = 3'd1;
            default:              last_step = 3'd0;
        endcase
    end

    always_comb
    begin
        out_free       = !rsp_valid_reg || rsp_ready;
        state_next     = state_reg;
        step_next      = step_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd            = '0;
        cmd.step       = step_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                step_next = 3'd0;
                if (stat.skip)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    case (stat.opcode)
                        mse_pkg::OP_REG_NODE: state_next = S_REG;
                        mse_pkg::OP_RESISTOR: state_next = S_DIV_START;
                        mse_pkg::OP_VSOURCE,
                        mse_pkg::OP_ISOURCE,
                        mse_pkg::OP_READ_MAT,
                        mse_pkg::OP_READ_RHS: state_next = S_ADDR;
                        default:              state_next = S_FIN;
                    endcase
                end
            end
            S_REG:
            begin
                cmd.reg_node = 1'b1;
                state_next   = S_FIN;
            end
            S_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                cmd.step_addr = 1'b1;
                state_next    = S_RD;
            end
            S_RD:
            begin
                cmd.step_rd = 1'b1;
                state_next  = S_WR;
            end
            S_WR:
            begin
                cmd.step_wr = 1'b1;
                if (step_reg == last_step)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    step_next  = step_reg + 3'd1;
                    state_next = S_ADDR;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.publish    = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            step_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule
`default_nettype wire

[hw/rtl/mna_stamp_engine.sv]
// Modified-nodal-analysis stamping engine. After reset the block runs a clearing pass over
// the matrix memory, one entry a cycle, and takes no transaction until it ends. Each
// command then passes through an idle state, a node-table scan over the registered nodes,
// a dispatch state and a publish state, and in between: a register step for register node;
// the bit-serial reciprocal divider plus four read-modify-write steps for a resistor, each
// an address, a read and a write state; five such address-read-write steps for a voltage
// source, two for a current source and one for a read; none for a command that fails its
// early checks. Results sit in an output register, so the next command is accepted while
// the previous result waits; a command finishes only once that register has been taken.
`default_nettype none
module mna_stamp_engine #(
    parameter int MAX_NODES    = mse_pkg::MAX_NODES_DEF,
    parameter int MAX_VSOURCES = mse_pkg::MAX_VSOURCES_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    mse_req_if.sink   req,
    mse_rsp_if.source rsp
);

    mse_pkg::dp_cmd_t  cmd;
    mse_pkg::dp_stat_t stat;

    mse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    mse_datapath #(
        .MAX_NODES    (MAX_NODES),
        .MAX_VSOURCES (MAX_VSOURCES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .opcode        (req.opcode),
        .node_a        (req.node_a),
        .node_b        (req.node_b),
        .elem_value    (req.elem_value),
        .source_slot   (req.source_slot),
        .read_row      (req.read_row),
        .read_col      (req.read_col),
        .read_value    (rsp.read_value),
        .status        (rsp.status),
        .node_count    (rsp.node_count)
    );

endmodule
`default_nettype wire
